[rtl/mt19937_generator_unit_macros.svh]
// Assertion macros used by the generator engine RTL (mtg_back).
`ifndef MT19937_GENERATOR_UNIT_MACROS_SVH
`define MT19937_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtg_pkg.sv]
// Shared constants, command types and tempering function for the MT19937 generator.
package mtg_pkg;

  localparam int WORD_COUNT = 624;
  localparam int SHIFT_GAP  = 397;
  localparam int WRAP_GAP   = WORD_COUNT - SHIFT_GAP;
  localparam int ADDR_W     = 10;
  localparam int DATA_W     = 32;
  localparam int Q_DEPTH    = 2;

  localparam logic [DATA_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [DATA_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [DATA_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [DATA_W-1:0] TEMPER_C     = 32'hefc6_0000;

  typedef enum logic [1:0] {
    CMD_SEED,
    CMD_NEXT,
    CMD_TWIST_NEXT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] seed;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

[rtl/mtg_in_if.sv]
// Input channel: operation and seed beats.
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

[rtl/mtg_out_if.sv]
// Result channel: tempered word beats.
interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic        word_valid;

  modport source (output valid, output random_word, output word_valid, input ready);
  modport sink   (input valid, input random_word, input word_valid, output ready);
endinterface

[rtl/mtg_queue.sv]
// Small command queue between the front end and the engine.
module mtg_queue
  import mtg_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = (cnt_r != CNT_W'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_cmd   = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

[rtl/mtg_front.sv]
// Front end: takes input beats, tracks the read index and classifies commands.
module mtg_front
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mtg_in_if.sink      in_ch,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;

  always_comb begin
    cmd.seed = in_ch.seed_value;
    if (!in_ch.operation) begin
      cmd.kind = CMD_SEED;
      cmd.addr = '0;
      idx_nxt  = ADDR_W'(WORD_COUNT);
    end else if (idx_r >= ADDR_W'(WORD_COUNT)) begin
      cmd.kind = CMD_TWIST_NEXT;
      cmd.addr = '0;
      idx_nxt  = ADDR_W'(1);
    end else begin
      cmd.kind = CMD_NEXT;
      cmd.addr = idx_r;
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= ADDR_W'(WORD_COUNT);
    end else if (accept) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[rtl/mtg_back.sv]
// Engine: state memory, seeding and twist sequencer, tempering and result register.
module mtg_back
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd_in,
  mtg_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SEED_MUL,
    B_SEED_ADD,
    B_TW_PRIME,
    B_TW_RUN,
    B_TW_DRAIN,
    B_RD,
    B_OUT
  } state_t;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(WORD_COUNT - 1);

  logic [DATA_W-1:0] mem [WORD_COUNT];
  logic [DATA_W-1:0] rda_r, rdb_r;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0] m_r, m_nxt;
  logic              p_r, p_nxt;
  logic              seeded_r, seeded_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic              out_v_r, out_v_nxt;
  logic [DATA_W-1:0] out_word_r, out_word_nxt;
  logic              out_wv_r, out_wv_nxt;

  logic [ADDR_W-1:0] ra, rb, wa, far_addr, nxt_addr;
  logic              we, out_free;
  logic [DATA_W-1:0] wd, ma, mb, mix, tw_val, seed_mix, seed_word;

  // never-seeded memory reads as zero
  assign ma        = seeded_r ? rda_r : '0;
  assign mb        = seeded_r ? rdb_r : '0;
  assign mix       = {cur_r[DATA_W-1], ma[DATA_W-2:0]};
  assign tw_val    = mb ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : '0);
  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_word = prod_r + DATA_W'(n_r);
  assign far_addr  = (n_r < ADDR_W'(WRAP_GAP)) ? n_r + ADDR_W'(SHIFT_GAP)
                                               : n_r - ADDR_W'(WRAP_GAP);
  assign nxt_addr  = (n_r == LAST) ? '0 : n_r + 1'b1;
  assign out_free  = !out_v_r || out_ch.ready;
  assign cmd_ready = (state_r == B_IDLE);

  assign out_ch.valid       = out_v_r;
  assign out_ch.random_word = out_word_r;
  assign out_ch.word_valid  = out_wv_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    p_nxt        = p_r;
    seeded_nxt   = seeded_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    prod_nxt     = prod_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_word_nxt = out_word_r;
    out_wv_nxt   = out_wv_r;
    ra           = cmd_r.addr;
    rb           = far_addr;
    we           = 1'b0;
    wa           = n_r;
    wd           = seed_word;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd_in;
          case (cmd_in.kind)
            CMD_SEED: begin
              we         = 1'b1;
              wa         = '0;
              wd         = cmd_in.seed;
              prev_nxt   = cmd_in.seed;
              n_nxt      = ADDR_W'(1);
              seeded_nxt = 1'b1;
              state_nxt  = B_SEED_MUL;
            end
            CMD_TWIST_NEXT: state_nxt = B_TW_PRIME;
            default:        state_nxt = B_RD;
          endcase
        end
      end
      B_SEED_MUL: begin
        prod_nxt  = INIT_MULT * seed_mix;
        state_nxt = B_SEED_ADD;
      end
      B_SEED_ADD: begin
        we       = 1'b1;
        prev_nxt = seed_word;
        if (n_r == LAST) begin
          state_nxt = B_OUT;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = B_SEED_MUL;
        end
      end
      B_TW_PRIME: begin
        ra        = '0;
        n_nxt     = '0;
        p_nxt     = 1'b0;
        state_nxt = B_TW_RUN;
      end
      B_TW_RUN: begin
        // issue reads for word n, retire word n-1
        ra      = nxt_addr;
        cur_nxt = ma;
        we      = p_r;
        wa      = m_r;
        wd      = tw_val;
        p_nxt   = 1'b1;
        m_nxt   = n_r;
        if (n_r == LAST) begin
          state_nxt = B_TW_DRAIN;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      B_TW_DRAIN: begin
        we        = 1'b1;
        wa        = m_r;
        wd        = tw_val;
        state_nxt = B_RD;
      end
      B_RD: begin
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          if (cmd_r.kind == CMD_SEED) begin
            out_word_nxt = '0;
            out_wv_nxt   = 1'b0;
          end else begin
            out_word_nxt = temper(ma);
            out_wv_nxt   = 1'b1;
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      seeded_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      out_v_r  <= out_v_nxt;
    end
    cmd_r      <= cmd_nxt;
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    p_r        <= p_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
    out_wv_r   <= out_wv_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

`include "mt19937_generator_unit_macros.svh"

  `MTG_ASSERT_IMP(a_drain_last, state_r == B_TW_DRAIN, m_r == LAST, "twist drain not on last word")
  `MTG_ASSERT_IMP(a_twist_from_zero, cmd_valid && cmd_ready && cmd_in.kind == CMD_TWIST_NEXT, cmd_in.addr == '0, "twist command not at word zero")
  `MTG_ASSERT_IMP(a_seed_beat_zero, out_v_r && !out_wv_r, out_word_r == '0, "seed beat carries a word")
  `MTG_ASSERT_NXT(a_result_loaded, state_r == B_OUT && out_free, out_v_r, "result not loaded")

endmodule

[rtl/mt19937_generator_unit.sv]
// MT19937 generator top level: front end, command queue and engine.
//
// Input channel in_ch carries operation and seed_value beats (valid/ready).
// operation 0 reseeds the 624-word state; operation 1 asks for the next word.
// Every input beat yields exactly one result beat on out_ch, in order:
// random_word with word_valid 1 for a next request, zero with word_valid 0
// for a seed.
// Timing: a next request passes through the queue, then the engine's B_RD
// state (registered memory read) and B_OUT state (tempering into the output
// register); the engine's single state memory and read-then-temper sequence
// mean it takes no new command until it is back in B_IDLE. Every 624th word
// first runs the twist, one word per cycle over the memory's two read ports.
// A seed fills the state word by word through the registered multiplier.
// The front end accepts beats into a QUEUE_DEPTH-entry queue while the engine
// is busy, and the engine keeps working while a finished result waits in the
// output register; in_ch.ready drops when the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// puts the generator in its unseeded state, where every word is zero; no
// clearing pass runs.
module mt19937_generator_unit
  import mtg_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mtg_in_if.sink     in_ch,
  mtg_out_if.source  out_ch
);

  logic fe_valid, fe_ready;
  cmd_t fe_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  mtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (fe_valid),
    .cmd_ready (fe_ready),
    .cmd       (fe_cmd)
  );

  mtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_cmd    (fe_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  mtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_in    (q_cmd),
    .out_ch    (out_ch)
  );

endmodule
